/* design/aperture_beam_phase_pixel_core_assert.svh */
// Assertion macros used by the pixel core design file.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef APERTURE_BEAM_PHASE_PIXEL_CORE_ASSERT_SVH
`define APERTURE_BEAM_PHASE_PIXEL_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ABPP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aperture core assertion failed");
`define ABPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aperture core assertion failed");
`else
`define ABPP_ASSERT_NOW(label, ante, cons)
`define ABPP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/abpp_pkg.sv */
package abpp_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIELD_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIELD_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_APERTURE_MODE   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_APERTURE_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_APERTURE_HEIGHT = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAUSSIAN_ENABLE = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BEAM_SCALE      = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BEAM_RADIUS     = 3'd7;

  // Aperture shapes.
  localparam logic [1:0] APERTURE_NONE    = 2'd0;
  localparam logic [1:0] APERTURE_RECT    = 2'd1;
  localparam logic [1:0] APERTURE_ELLIPSE = 2'd2;

  // Phase quadrants.
  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  // Fixed point constants.
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;

  // Series and divider sizes.
  localparam int ENV_TERMS     = 12;
  localparam int TRIG_TERMS    = 20;
  localparam int ENV_SQUARINGS = 4;
  localparam int GX_BITS       = 21;
  localparam int DIV_STEPS     = 21;
  localparam logic [GX_BITS-1:0] GX_MAX = 21'h10_0000;

  typedef struct packed {
    logic [12:0] field_width;
    logic [12:0] field_height;
    logic [1:0]  aperture_mode;
    logic [12:0] aperture_width;
    logic [12:0] aperture_height;
    logic        gaussian_enable;
    logic [31:0] beam_scale;
    logic [31:0] beam_radius;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    field_width:     13'd512,
    field_height:    13'd512,
    aperture_mode:   APERTURE_NONE,
    aperture_width:  13'd0,
    aperture_height: 13'd0,
    gaussian_enable: 1'b0,
    beam_scale:      32'd65536,
    beam_radius:     32'd65536
  };

endpackage

/* design/aperture_beam_phase_pixel_core.sv */
// Source pixel generator for a phase modulator field.
// Input channel: in_valid / in_stall carry one pixel word (column, row, phase_fraction).
// Output channel: out_valid / out_stall carry one result word (pixel_address,
// amplitude, phasor_real, phasor_imag) for every input word, in order.
// Configuration: cfg_write, cfg_index and cfg_data write one register per cycle;
// the user must change registers only while no word is in flight; the block
// itself does not enforce it. Throughput: one word per cycle while in_stall is low.
// The depth is set by the two per-axis restoring dividers (21 steps), the 12-term
// envelope series and its squarings; the 20-term sine/cosine series runs beside
// them, three stages per series term.
// Reset (rst, synchronous) empties the pipeline, clears out_valid and loads the
// register defaults.
// When the receiver stalls, the result word holds in the output register while the
// pipeline keeps filling its empty slots; in_stall rises only when a finished word
// waits behind the held output.
module aperture_beam_phase_pixel_core #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [COORD_BITS-1:0]                 column,
  input  logic [COORD_BITS-1:0]                 row,
  input  logic [FRAC_BITS-1:0]                  phase_fraction,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2*COORD_BITS-1:0]               pixel_address,
  output logic [FRAC_BITS:0]                    amplitude,
  output logic signed [15:0]                    phasor_real,
  output logic signed [15:0]                    phasor_imag,
  input  logic                                  cfg_write,
  input  logic [abpp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [abpp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int XW   = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
  localparam int RW   = 48 + XW;
  localparam int AB   = 2 * COORD_BITS;
  localparam int SUMW = (AB > COORD_BITS + 14) ? AB : COORD_BITS + 14;
  localparam int FW1  = FRAC_BITS + 1;
  localparam int XX   = 2 * XW;
  localparam int EW   = XX + 26;

  localparam int ADDR_STAGE   = 3;
  localparam int MASK_STAGE   = 5;
  localparam int SUM_STAGE    = 28;
  localparam int AMP_STAGE    = SUM_STAGE + 3 * abpp_pkg::ENV_TERMS + 1
                                + abpp_pkg::ENV_SQUARINGS + 1;
  localparam int PHASOR_STAGE = 2 + 3 * abpp_pkg::TRIG_TERMS + 1;
  localparam int LAT          = AMP_STAGE;
  localparam int INSIDE_DLY   = AMP_STAGE - 1 - MASK_STAGE;
  localparam int OVER_DLY     = AMP_STAGE - 1 - SUM_STAGE;
  localparam int PH_DLY       = AMP_STAGE - PHASOR_STAGE;
  localparam int ADDR_DLY     = AMP_STAGE - ADDR_STAGE;
  localparam int QUAD_DLY     = PHASOR_STAGE - 1 - 2;

  localparam logic [FW1-1:0] AMP_ONE = FW1'(1) << FRAC_BITS;

  abpp_pkg::cfg_t cfg;

  logic           advance;
  logic [LAT:1]   vld;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= abpp_pkg::CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        abpp_pkg::REG_FIELD_WIDTH:     cfg.field_width     <= cfg_data[12:0];
        abpp_pkg::REG_FIELD_HEIGHT:    cfg.field_height    <= cfg_data[12:0];
        abpp_pkg::REG_APERTURE_MODE:   cfg.aperture_mode   <= cfg_data[1:0];
        abpp_pkg::REG_APERTURE_WIDTH:  cfg.aperture_width  <= cfg_data[12:0];
        abpp_pkg::REG_APERTURE_HEIGHT: cfg.aperture_height <= cfg_data[12:0];
        abpp_pkg::REG_GAUSSIAN_ENABLE: cfg.gaussian_enable <= cfg_data[0];
        abpp_pkg::REG_BEAM_SCALE:      cfg.beam_scale      <= cfg_data;
        abpp_pkg::REG_BEAM_RADIUS:     cfg.beam_radius     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Aperture bounds, registered from the configuration registers.
  logic [23:0] aw_sq;
  logic [23:0] ah_sq;
  logic [25:0] eaw;
  logic [25:0] eah;
  logic [51:0] eawah;

  always_ff @(posedge clk) begin
    aw_sq <= 24'(cfg.aperture_width[12:1]) * 24'(cfg.aperture_width[12:1]);
    ah_sq <= 24'(cfg.aperture_height[12:1]) * 24'(cfg.aperture_height[12:1]);
    eaw   <= 26'(cfg.aperture_width) * 26'(cfg.aperture_width);
    eah   <= 26'(cfg.aperture_height) * 26'(cfg.aperture_height);
    eawah <= 52'(eaw) * 52'(eah);
  end

  // Pipeline control: everything moves together unless a finished word would
  // overwrite a held output.
  assign advance  = !(vld[LAT] && out_valid && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  // Stage 1: input capture.
  logic [COORD_BITS-1:0] col1;
  logic [COORD_BITS-1:0] row1;
  logic [FRAC_BITS-1:0]  ph1;

  always_ff @(posedge clk) begin
    if (advance) begin
      col1 <= column;
      row1 <= row;
      ph1  <= phase_fraction;
    end
  end

  // Stage 2: centered coordinates, address product, phase angle.
  logic [XW-1:0]              crd2 [2];
  logic [COORD_BITS-1:0]      col2;
  logic [COORD_BITS+12:0]     rowprod2;
  logic [1:0]                 quad2;
  logic [FRAC_BITS+28:0]      thprod;

  assign thprod = (FRAC_BITS+29)'(ph1[FRAC_BITS-3:0]) * (FRAC_BITS+29)'(abpp_pkg::HALFPI_Q30);

  always_ff @(posedge clk) begin
    if (advance) begin
      crd2[0]  <= XW'(col1) - XW'(cfg.field_width[12:1]) + XW'(1);
      crd2[1]  <= XW'(row1) - XW'(cfg.field_height[12:1]) + XW'(1);
      col2     <= col1;
      rowprod2 <= (COORD_BITS+13)'(row1) * (COORD_BITS+13)'(cfg.field_width);
      quad2    <= ph1[FRAC_BITS-1:FRAC_BITS-2];
    end
  end

  // Stage 3: address sum, squared coordinates, envelope numerators.
  logic [XW-1:0]      mag2 [2];
  logic [AB-1:0]      addr3;
  logic [XX-1:0]      sq3 [2];
  logic [31+XW:0]     bnum3 [2];

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis_front
    assign mag2[ax] = crd2[ax][XW-1] ? (XW'(0) - crd2[ax]) : crd2[ax];
    always_ff @(posedge clk) begin
      if (advance) begin
        sq3[ax]   <= XX'(mag2[ax]) * XX'(mag2[ax]);
        bnum3[ax] <= (32+XW)'(cfg.beam_scale) * (32+XW)'(mag2[ax]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      addr3 <= AB'(SUMW'(col2) + SUMW'(rowprod2));
    end
  end

  // Stages 4 and 5: aperture test.
  logic          rect4;
  logic [EW-1:0] ell4 [2];
  logic [EW:0]   ellsum;
  logic          inside5;

  assign ellsum = (EW+1)'(ell4[0]) + (EW+1)'(ell4[1]);

  always_ff @(posedge clk) begin
    if (advance) begin
      rect4   <= (sq3[0] <= XX'(aw_sq)) && (sq3[1] <= XX'(ah_sq));
      ell4[0] <= EW'(sq3[0]) * EW'(eah);
      ell4[1] <= EW'(sq3[1]) * EW'(eaw);
      case (cfg.aperture_mode)
        abpp_pkg::APERTURE_RECT:    inside5 <= rect4;
        abpp_pkg::APERTURE_ELLIPSE: inside5 <= ellsum <= (EW+1)'(eawah);
        default:                    inside5 <= 1'b1;
      endcase
    end
  end

  // Stages 4 to 25: restoring divide of h*|coord|*2^16 by r, one quotient bit a stage.
  logic [RW-1:0]                    drem  [2][abpp_pkg::DIV_STEPS+1];
  logic [abpp_pkg::GX_BITS-1:0]     dquo  [2][abpp_pkg::DIV_STEPS+1];
  logic                             dsat  [2][abpp_pkg::DIV_STEPS+1];
  logic                             dzero [2][abpp_pkg::DIV_STEPS+1];
  logic [abpp_pkg::GX_BITS-1:0]     gx26  [2];
  logic [41:0]                      gsq27 [2];

  for (genvar ax = 0; ax < 2; ax++) begin : g_div
    always_ff @(posedge clk) begin
      if (advance) begin
        drem[ax][0]  <= {bnum3[ax], 16'd0};
        dquo[ax][0]  <= '0;
        dsat[ax][0]  <= {bnum3[ax], 16'd0} >= (RW'(cfg.beam_radius) << abpp_pkg::DIV_STEPS);
        dzero[ax][0] <= bnum3[ax] == '0;
      end
    end

    for (genvar j = 1; j <= abpp_pkg::DIV_STEPS; j++) begin : g_step
      localparam int KB = abpp_pkg::DIV_STEPS - j;
      logic [RW-1:0] den;
      assign den = RW'(cfg.beam_radius) << KB;
      always_ff @(posedge clk) begin
        if (advance) begin
          dsat[ax][j]  <= dsat[ax][j-1];
          dzero[ax][j] <= dzero[ax][j-1];
          if (drem[ax][j-1] >= den) begin
            drem[ax][j] <= drem[ax][j-1] - den;
            dquo[ax][j] <= {dquo[ax][j-1][abpp_pkg::GX_BITS-2:0], 1'b1};
          end else begin
            drem[ax][j] <= drem[ax][j-1];
            dquo[ax][j] <= {dquo[ax][j-1][abpp_pkg::GX_BITS-2:0], 1'b0};
          end
        end
      end
    end

    // Clamp to 16.0 and square.
    always_ff @(posedge clk) begin
      if (advance) begin
        if (dzero[ax][abpp_pkg::DIV_STEPS]) begin
          gx26[ax] <= '0;
        end else if (dsat[ax][abpp_pkg::DIV_STEPS] ||
                     dquo[ax][abpp_pkg::DIV_STEPS] > abpp_pkg::GX_MAX) begin
          gx26[ax] <= abpp_pkg::GX_MAX;
        end else begin
          gx26[ax] <= dquo[ax][abpp_pkg::DIV_STEPS];
        end
        gsq27[ax] <= 42'(gx26[ax]) * 42'(gx26[ax]);
      end
    end
  end

  // Stage 28: radius squared, out-of-range flag and series argument.
  logic [42:0] ssum;
  logic        over28;
  logic [30:0] et [abpp_pkg::ENV_TERMS+1];
  logic [29:0] eu [abpp_pkg::ENV_TERMS+1];
  logic signed [32:0] es [abpp_pkg::ENV_TERMS+1];
  logic [60:0] ep  [1:abpp_pkg::ENV_TERMS];
  logic [60:0] ew  [1:abpp_pkg::ENV_TERMS];
  logic [29:0] eua [1:abpp_pkg::ENV_TERMS];
  logic [29:0] eub [1:abpp_pkg::ENV_TERMS];
  logic signed [32:0] esa [1:abpp_pkg::ENV_TERMS];
  logic signed [32:0] esb [1:abpp_pkg::ENV_TERMS];

  assign ssum  = 43'(gsq27[0]) + 43'(gsq27[1]);
  assign et[0] = abpp_pkg::Q30_ONE;
  assign es[0] = $signed({2'b00, abpp_pkg::Q30_ONE});

  always_ff @(posedge clk) begin
    if (advance) begin
      over28 <= ssum >= (43'd1 << 36);
      eu[0]  <= ssum[35:6];
    end
  end

  // Envelope series exp(-u), three stages a term: product, reciprocal product, update.
  for (genvar i = 1; i <= abpp_pkg::ENV_TERMS; i++) begin : g_env
    localparam int L = $clog2(i);
    localparam int K = 30 + L;
    localparam logic [63:0] MW = ((64'd1 << K) + 64'(i) - 64'd1) / 64'(i);
    localparam logic [30:0] M = MW[30:0];
    logic [30:0] tn;
    assign tn = 31'(ew[i] >> K);
    always_ff @(posedge clk) begin
      if (advance) begin
        ep[i]  <= 61'(et[i-1]) * 61'(eu[i-1]);
        eua[i] <= eu[i-1];
        esa[i] <= es[i-1];
        ew[i]  <= 61'(ep[i][59:30]) * 61'(M);
        eub[i] <= eua[i];
        esb[i] <= esa[i];
        et[i]  <= tn;
        eu[i]  <= eub[i];
      end
    end
    if (i % 2 == 1) begin : g_odd
      always_ff @(posedge clk) begin
        if (advance) begin
          es[i] <= esb[i] - $signed({2'b00, tn});
        end
      end
    end else begin : g_even
      always_ff @(posedge clk) begin
        if (advance) begin
          es[i] <= esb[i] + $signed({2'b00, tn});
        end
      end
    end
  end

  // Clamp at zero, then raise to the sixteenth power by repeated squaring.
  logic [30:0] esq [abpp_pkg::ENV_SQUARINGS+1];

  always_ff @(posedge clk) begin
    if (advance) begin
      esq[0] <= (es[abpp_pkg::ENV_TERMS] < 0) ? 31'd0 : es[abpp_pkg::ENV_TERMS][30:0];
    end
  end

  for (genvar k = 1; k <= abpp_pkg::ENV_SQUARINGS; k++) begin : g_square
    always_ff @(posedge clk) begin
      if (advance) begin
        esq[k] <= 31'(((62'(esq[k-1]) * 62'(esq[k-1])) + (62'd1 << 29)) >> 30);
      end
    end
  end

  // Mask and out-of-range flag travel with the word.
  logic inside_d [INSIDE_DLY];
  logic over_d   [OVER_DLY];

  always_ff @(posedge clk) begin
    if (advance) begin
      inside_d[0] <= inside5;
      for (int k = 1; k < INSIDE_DLY; k++) begin
        inside_d[k] <= inside_d[k-1];
      end
      over_d[0] <= over28;
      for (int k = 1; k < OVER_DLY; k++) begin
        over_d[k] <= over_d[k-1];
      end
    end
  end

  // Final amplitude.
  logic [FW1-1:0] amp_env;
  logic [FW1-1:0] amp70;

  assign amp_env = FW1'((32'(esq[abpp_pkg::ENV_SQUARINGS]) + (32'd1 << (29 - FRAC_BITS)))
                        >> (30 - FRAC_BITS));

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!inside_d[INSIDE_DLY-1]) begin
        amp70 <= '0;
      end else if (cfg.gaussian_enable) begin
        amp70 <= over_d[OVER_DLY-1] ? FW1'(0) : amp_env;
      end else begin
        amp70 <= AMP_ONE;
      end
    end
  end

  // Sine and cosine series over the first quadrant, three stages a term.
  logic [30:0]        pt  [abpp_pkg::TRIG_TERMS+1];
  logic [30:0]        pth [abpp_pkg::TRIG_TERMS+1];
  logic signed [34:0] pc  [abpp_pkg::TRIG_TERMS+1];
  logic signed [34:0] ps  [abpp_pkg::TRIG_TERMS+1];
  logic [61:0]        pp  [1:abpp_pkg::TRIG_TERMS];
  logic [65:0]        pw  [1:abpp_pkg::TRIG_TERMS];
  logic [30:0]        tha [1:abpp_pkg::TRIG_TERMS];
  logic [30:0]        thb [1:abpp_pkg::TRIG_TERMS];
  logic signed [34:0] pca [1:abpp_pkg::TRIG_TERMS];
  logic signed [34:0] pcb [1:abpp_pkg::TRIG_TERMS];
  logic signed [34:0] psa [1:abpp_pkg::TRIG_TERMS];
  logic signed [34:0] psb [1:abpp_pkg::TRIG_TERMS];

  assign pt[0] = abpp_pkg::Q30_ONE;
  assign pc[0] = $signed({4'b0000, abpp_pkg::Q30_ONE});
  assign ps[0] = '0;

  always_ff @(posedge clk) begin
    if (advance) begin
      pth[0] <= thprod[FRAC_BITS+28:FRAC_BITS-2];
    end
  end

  for (genvar n = 1; n <= abpp_pkg::TRIG_TERMS; n++) begin : g_trig
    localparam int L = $clog2(n);
    localparam int K = 32 + L;
    localparam logic [63:0] MW = ((64'd1 << K) + 64'(n) - 64'd1) / 64'(n);
    localparam logic [33:0] M = MW[33:0];
    logic [30:0]        tn;
    logic signed [34:0] tx;
    assign tn = 31'(pw[n] >> K);
    assign tx = $signed({4'b0000, tn});
    always_ff @(posedge clk) begin
      if (advance) begin
        pp[n]  <= 62'(pt[n-1]) * 62'(pth[n-1]);
        tha[n] <= pth[n-1];
        pca[n] <= pc[n-1];
        psa[n] <= ps[n-1];
        pw[n]  <= 66'(pp[n][61:30]) * 66'(M);
        thb[n] <= tha[n];
        pcb[n] <= pca[n];
        psb[n] <= psa[n];
        pt[n]  <= tn;
        pth[n] <= thb[n];
      end
    end
    if (n % 4 == 1) begin : g_sin_add
      always_ff @(posedge clk) begin
        if (advance) begin
          ps[n] <= psb[n] + tx;
          pc[n] <= pcb[n];
        end
      end
    end else if (n % 4 == 2) begin : g_cos_sub
      always_ff @(posedge clk) begin
        if (advance) begin
          ps[n] <= psb[n];
          pc[n] <= pcb[n] - tx;
        end
      end
    end else if (n % 4 == 3) begin : g_sin_sub
      always_ff @(posedge clk) begin
        if (advance) begin
          ps[n] <= psb[n] - tx;
          pc[n] <= pcb[n];
        end
      end
    end else begin : g_cos_add
      always_ff @(posedge clk) begin
        if (advance) begin
          ps[n] <= psb[n];
          pc[n] <= pcb[n] + tx;
        end
      end
    end
  end

  // Quadrant travels alongside the series.
  logic [1:0] quad_d [QUAD_DLY];

  always_ff @(posedge clk) begin
    if (advance) begin
      quad_d[0] <= quad2;
      for (int k = 1; k < QUAD_DLY; k++) begin
        quad_d[k] <= quad_d[k-1];
      end
    end
  end

  // Clamp to [0, 1.0] and round a Q30 value to Q15 magnitude.
  function automatic logic [15:0] to_q15(input logic signed [34:0] v);
    logic [30:0] cl;
    if (v < 0) begin
      cl = '0;
    end else if (v > $signed({4'b0000, abpp_pkg::Q30_ONE})) begin
      cl = abpp_pkg::Q30_ONE;
    end else begin
      cl = v[30:0];
    end
    return 16'((32'(cl) + 32'd16384) >> 15);
  endfunction

  function automatic logic [15:0] pos15(input logic [15:0] m);
    return (m > 16'd32767) ? 16'd32767 : m;
  endfunction

  function automatic logic [15:0] neg15(input logic [15:0] m);
    return 16'(17'd0 - {1'b0, m});
  endfunction

  // Rotate the first-quadrant phasor into place.
  logic [15:0] mc;
  logic [15:0] ms;
  logic [15:0] re63;
  logic [15:0] im63;

  assign mc = to_q15(pc[abpp_pkg::TRIG_TERMS]);
  assign ms = to_q15(ps[abpp_pkg::TRIG_TERMS]);

  always_ff @(posedge clk) begin
    if (advance) begin
      case (quad_d[QUAD_DLY-1])
        abpp_pkg::QUAD_FIRST: begin
          re63 <= pos15(mc);
          im63 <= pos15(ms);
        end
        abpp_pkg::QUAD_SECOND: begin
          re63 <= neg15(ms);
          im63 <= pos15(mc);
        end
        abpp_pkg::QUAD_THIRD: begin
          re63 <= neg15(mc);
          im63 <= neg15(ms);
        end
        default: begin
          re63 <= pos15(ms);
          im63 <= neg15(mc);
        end
      endcase
    end
  end

  // Phasor and address delays to the amplitude stage.
  logic [15:0]   re_d   [PH_DLY];
  logic [15:0]   im_d   [PH_DLY];
  logic [AB-1:0] addr_d [ADDR_DLY];

  always_ff @(posedge clk) begin
    if (advance) begin
      re_d[0] <= re63;
      im_d[0] <= im63;
      for (int k = 1; k < PH_DLY; k++) begin
        re_d[k] <= re_d[k-1];
        im_d[k] <= im_d[k-1];
      end
      addr_d[0] <= addr3;
      for (int k = 1; k < ADDR_DLY; k++) begin
        addr_d[k] <= addr_d[k-1];
      end
    end
  end

  // Output register; it holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= vld[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      pixel_address <= addr_d[ADDR_DLY-1];
      amplitude     <= amp70;
      phasor_real   <= $signed(re_d[PH_DLY-1]);
      phasor_imag   <= $signed(im_d[PH_DLY-1]);
    end
  end

`include "aperture_beam_phase_pixel_core_assert.svh"

  `ABPP_ASSERT_NOW(a_stall_needs_full_tail, in_stall, vld[LAT] && out_valid && out_stall)
  `ABPP_ASSERT_NEXT(a_frozen_pipe_keeps_slots, !advance, $stable(vld))
  `ABPP_ASSERT_NOW(a_amplitude_in_range, out_valid, amplitude <= AMP_ONE)
  `ABPP_ASSERT_NOW(a_phasor_not_null, out_valid, (phasor_real != 16'sd0) || (phasor_imag != 16'sd0))

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int  CLK_HALF    = 6;
  localparam int  LATENCY     = 71;
  localparam int  NUM_PHASES  = 10;
  localparam int  PER_PHASE   = 175;
  localparam int  HOLD_CYCLES = 300;
  localparam int  IDLE_PCT    = 11;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [23:0]        addr;
    logic [16:0]        amp;
    logic signed [15:0] re;
    logic signed [15:0] im;
  } pixel_word_t;

  // Pixel predictor: keeps a copy of the registers and a queue of expected words.
  class pixel_scoreboard;
    abpp_pkg::cfg_t regs;
    pixel_word_t    expected_words[$];
    int             errors;

    function new();
      regs   = abpp_pkg::CFG_RESET;
      errors = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // Normalized beam coordinate in Q16.16, limited to 16.0.
    function longint unsigned beam_coord(longint unsigned mag);
      longint unsigned q;
      if (mag == 0 || regs.beam_scale == 0) return 0;
      if (regs.beam_radius == 0) return 64'd16 << 16;
      q = ((longint'(regs.beam_scale) * mag) << 16) / longint'(regs.beam_radius);
      return (q > (64'd16 << 16)) ? (64'd16 << 16) : q;
    endfunction

    // exp(-s) in Q30 from s in Q32: series on s/16, then four squarings.
    function longint unsigned envelope(longint unsigned s);
      longint unsigned u, t, e;
      longint sum;
      if (s >= (64'd16 << 32)) return 0;
      u   = s >> 6;
      t   = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (int i = 1; i <= abpp_pkg::ENV_TERMS; i++) begin
        t = ((t * u) >> 30) / i;
        if (i % 2 == 1) sum -= longint'(t);
        else sum += longint'(t);
      end
      if (sum < 0) sum = 0;
      e = sum;
      for (int i = 0; i < abpp_pkg::ENV_SQUARINGS; i++) e = (e * e + (64'd1 << 29)) >> 30;
      return e;
    endfunction

    function longint unsigned to_q15(longint v);
      if (v < 0) v = 0;
      if (v > (64'sd1 << 30)) v = 64'sd1 << 30;
      return (longint'(v) + (64'd1 << 14)) >> 15;
    endfunction

    function logic signed [15:0] sat_pos(longint unsigned m);
      return (m > 32767) ? 16'sd32767 : 16'(m);
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row, logic [15:0] ph);
      longint      x, y, aw, ah, eaw, eah, c, s;
      longint unsigned gx, gy, amp, theta, t, a, mc, ms, addr;
      bit          in_aperture;
      pixel_word_t w;
      x   = longint'(col) - longint'(regs.field_width / 2) + 1;
      y   = longint'(row) - longint'(regs.field_height / 2) + 1;
      aw  = regs.aperture_width / 2;
      ah  = regs.aperture_height / 2;
      eaw = longint'(regs.aperture_width) * longint'(regs.aperture_width);
      eah = longint'(regs.aperture_height) * longint'(regs.aperture_height);
      case (regs.aperture_mode)
        abpp_pkg::APERTURE_RECT:
          in_aperture = (x * x <= aw * aw) && (y * y <= ah * ah);
        abpp_pkg::APERTURE_ELLIPSE:
          in_aperture = (x * x * eah + eaw * y * y) <= eaw * eah;
        default:
          in_aperture = 1'b1;
      endcase
      if (!in_aperture) begin
        amp = 0;
      end else if (regs.gaussian_enable) begin
        gx  = beam_coord(x < 0 ? -x : x);
        gy  = beam_coord(y < 0 ? -y : y);
        amp = (envelope(gx * gx + gy * gy) + (64'd1 << 13)) >> 14;
      end else begin
        amp = 64'd1 << 16;
      end

      // First-quadrant angle, then Taylor series for cos and sin.
      a     = ph[13:0];
      theta = (a * longint'(abpp_pkg::HALFPI_Q30)) >> 14;
      t     = 64'd1 << 30;
      c     = 64'sd1 << 30;
      s     = 0;
      for (int n = 1; n <= abpp_pkg::TRIG_TERMS; n++) begin
        t = ((t * theta) >> 30) / n;
        case (n % 4)
          1: s += longint'(t);
          2: c -= longint'(t);
          3: s -= longint'(t);
          default: c += longint'(t);
        endcase
      end
      mc = to_q15(c);
      ms = to_q15(s);
      case (ph[15:14])
        abpp_pkg::QUAD_FIRST:  begin w.re = sat_pos(mc); w.im = sat_pos(ms); end
        abpp_pkg::QUAD_SECOND: begin w.re = -16'(ms);    w.im = sat_pos(mc); end
        abpp_pkg::QUAD_THIRD:  begin w.re = -16'(mc);    w.im = -16'(ms);    end
        default:               begin w.re = sat_pos(ms); w.im = -16'(mc);    end
      endcase
      addr   = longint'(col) + longint'(row) * longint'(regs.field_width);
      w.addr = addr[23:0];
      w.amp  = amp[16:0];
      expected_words.push_back(w);
    endfunction

    task check_word(pixel_word_t got);
      pixel_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word addr=%0d", got.addr));
        return;
      end
      want = expected_words.pop_front();
      if (got.addr !== want.addr)
        report($sformatf("address got %0d want %0d", got.addr, want.addr));
      if (got.amp !== want.amp)
        report($sformatf("amplitude got %0d want %0d (addr %0d)", got.amp, want.amp,
                         want.addr));
      if (got.re !== want.re)
        report($sformatf("real got %0d want %0d (addr %0d)", got.re, want.re, want.addr));
      if (got.im !== want.im)
        report($sformatf("imag got %0d want %0d (addr %0d)", got.im, want.im, want.addr));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [11:0] column;
  logic [11:0] row;
  logic [15:0] phase_fraction;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] pixel_address;
  logic [16:0] amplitude;
  logic signed [15:0] phasor_real;
  logic signed [15:0] phasor_imag;
  logic        cfg_write;
  logic [abpp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [abpp_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  pixel_scoreboard pixels;
  bit          quiet;
  bit          hold_go;
  bit          hold_out;
  longint      cycles;

  aperture_beam_phase_pixel_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .column(column), .row(row), .phase_fraction(phase_fraction),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_address(pixel_address), .amplitude(amplitude),
    .phasor_real(phasor_real), .phasor_imag(phasor_imag),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock.
  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Run limit.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: check each accepted word and pick the next stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      pixels.check_word('{pixel_address, amplitude, phasor_real, phasor_imag});
    out_stall <= hold_out || (!quiet && $urandom_range(0, 99) < IDLE_PCT);
  end

  // Long receiver hold-off, counted here while the sender keeps going.
  initial begin
    hold_out = 1'b0;
    @(posedge clk iff hold_go);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  task automatic send_pixel(logic [11:0] c, logic [11:0] r, logic [15:0] p);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    column         <= c;
    row            <= r;
    phase_fraction <= p;
    do @(posedge clk); while (in_stall);
    pixels.note_pixel(c, r, p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixels.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all eight registers back to back.
  task automatic load_regs(abpp_pkg::cfg_t v);
    logic [31:0] vals[8];
    vals[abpp_pkg::REG_FIELD_WIDTH]     = v.field_width;
    vals[abpp_pkg::REG_FIELD_HEIGHT]    = v.field_height;
    vals[abpp_pkg::REG_APERTURE_MODE]   = v.aperture_mode;
    vals[abpp_pkg::REG_APERTURE_WIDTH]  = v.aperture_width;
    vals[abpp_pkg::REG_APERTURE_HEIGHT] = v.aperture_height;
    vals[abpp_pkg::REG_GAUSSIAN_ENABLE] = v.gaussian_enable;
    vals[abpp_pkg::REG_BEAM_SCALE]      = v.beam_scale;
    vals[abpp_pkg::REG_BEAM_RADIUS]     = v.beam_radius;
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[abpp_pkg::CFG_INDEX_BITS-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    pixels.regs = v;
  endtask

  function automatic abpp_pkg::cfg_t phase_regs(int k);
    abpp_pkg::cfg_t v;
    v = abpp_pkg::CFG_RESET;
    case (k)
      1: begin
        v.field_width = 4096; v.field_height = 4096;
        v.aperture_mode = abpp_pkg::APERTURE_RECT;
        v.aperture_width = 300; v.aperture_height = 160; v.gaussian_enable = 1;
        v.beam_scale = 32'h0001_0000; v.beam_radius = 32'h0040_0000;
      end
      2: begin
        v.field_width = 2; v.field_height = 2;
        v.aperture_mode = abpp_pkg::APERTURE_ELLIPSE;
        v.aperture_width = 4096; v.aperture_height = 4096; v.gaussian_enable = 1;
        v.beam_scale = 32'hFFFF_FFFF; v.beam_radius = 32'hFFFF_FFFF;
      end
      3: begin
        // Undefined aperture code, an odd field width, a zero field height and a zero beam radius.
        v.field_width = 8191; v.field_height = 0; v.aperture_mode = 2'd3;
        v.gaussian_enable = 1; v.beam_scale = 32'h0000_8000; v.beam_radius = 0;
      end
      4: begin
        v.field_width = 1; v.field_height = 3;
        v.aperture_mode = abpp_pkg::APERTURE_ELLIPSE;
        v.aperture_width = 0; v.aperture_height = 0;
      end
      5: begin
        v.field_width = 64; v.field_height = 32;
        v.aperture_mode = abpp_pkg::APERTURE_RECT;
        v.aperture_width = 1; v.aperture_height = 0; v.gaussian_enable = 1;
        v.beam_scale = 0; v.beam_radius = 1;
      end
      default: begin
        v.field_width     = $urandom_range(2, 4096);
        v.field_height    = $urandom_range(2, 4096);
        v.aperture_mode   = $urandom_range(0, 3);
        v.aperture_width  = $urandom_range(0, 600);
        v.aperture_height = $urandom_range(0, 600);
        v.gaussian_enable = $urandom_range(0, 3) != 0;
        v.beam_scale      = $urandom_range(32'h4000, 32'h8_0000);
        v.beam_radius     = $urandom_range(32'h4_0000, 32'h100_0000);
        if ($urandom_range(0, 4) == 0) v.beam_scale = $urandom;
      end
    endcase
    return v;
  endfunction

  // Random pixel, often near the field center so the envelope stays nonzero.
  task automatic send_random();
    int          cx, cy;
    logic [11:0] c, r;
    if ($urandom_range(0, 1) == 0) begin
      cx = int'(pixels.regs.field_width / 2) - 1 + $urandom_range(0, 160) - 80;
      cy = int'(pixels.regs.field_height / 2) - 1 + $urandom_range(0, 160) - 80;
      c  = cx[11:0];
      r  = cy[11:0];
    end else begin
      c = $urandom;
      r = $urandom;
    end
    send_pixel(c, r, $urandom);
  endtask

  initial begin
    logic [15:0] corner_phases[10];
    pixels         = new();
    rst            = 1'b1;
    in_valid       = 1'b0;
    column         = '0;
    row            = '0;
    phase_fraction = '0;
    out_stall      = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    quiet          = 1'b0;
    hold_go        = 1'b0;
    corner_phases  = '{16'h0000, 16'h0001, 16'h2000, 16'h3FFF, 16'h4000,
                       16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed words on the reset settings: coordinate extremes and quadrant edges.
    foreach (corner_phases[i])
      send_pixel(i[0] ? 12'hFFF : 12'h000, i[1] ? 12'hFFF : 12'd255, corner_phases[i]);
    send_pixel(12'd255, 12'd255, 16'h1234);
    send_pixel(12'hAAA, 12'h555, 16'h5555);
    send_pixel(12'h555, 12'hAAA, 16'hAAAA);

    for (int k = 0; k < NUM_PHASES; k++) begin
      if (k > 0) begin
        drain();
        load_regs(phase_regs(k));
      end
      for (int n = 0; n < PER_PHASE; n++) begin
        quiet = (k == 6) && (n < 120);
        if (k == 2 && n == 20) hold_go = 1'b1;
        if (k == 7 && n == 60) begin
          in_valid <= 1'b0;
          while (pixels.pending() != 0) @(posedge clk);
        end
        send_random();
      end
    end

    drain();
    repeat (LATENCY + 20) @(posedge clk);
    if (pixels.pending() != 0) pixels.report("words still expected at end");
    if (pixels.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
